// File: hw/rtl/b2da_pkg.sv
// Shared constants and helper functions for the binary to decimal ASCII unit.
package b2da_pkg;

  localparam int VALUE_W = 32;
  localparam int CHAR_W = 6;
  localparam int CNT_W = 4;
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int DIGIT_W = 4;
  // Decimal digits needed for the widest 32-bit value
  localparam int DEC_DIGITS_32 = 10;
  localparam int MAX_DIGITS_DEF = 10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // 10^n, evaluated at elaboration only
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < n && k < 19; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Largest value representable in n decimal digits, capped to 32 bits
  function automatic logic [VALUE_W-1:0] sat_limit(input int n);
    logic [63:0] lim;
    if (n < DEC_DIGITS_32) begin
      lim = pow10(n) - 64'd1;
    end else begin
      lim = 64'hFFFF_FFFF;
    end
    return lim[VALUE_W-1:0];
  endfunction

endpackage

// File: hw/rtl/b2da_dabble.sv
// Shift-add-3 step: adjusts every BCD digit and shifts in one binary bit.
module b2da_dabble #(
  parameter int NDIG = b2da_pkg::DEC_DIGITS_32
) (
  input  logic [b2da_pkg::DIGIT_W*NDIG-1:0] bcd_in,
  input  logic                              bit_in,
  output logic [b2da_pkg::DIGIT_W*NDIG-1:0] bcd_out
);

  localparam int DW = b2da_pkg::DIGIT_W;
  localparam int BCD_W = DW * NDIG;

  logic [BCD_W-1:0] adj;

  // Add three to each digit of five or more, then shift left by one
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_in[i*DW +: DW] >= 4'd5) begin
        adj[i*DW +: DW] = bcd_in[i*DW +: DW] + 4'd3;
      end else begin
        adj[i*DW +: DW] = bcd_in[i*DW +: DW];
      end
    end
    bcd_out = {adj[BCD_W-2:0], bit_in};
  end

endmodule

// File: hw/rtl/binary_to_decimal_ascii_unit.sv
// Top level: sequencer that converts a 32-bit value to ASCII decimal characters.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, value[31:0]           | in
//  output  | out_valid, out_ready, digit_char[5:0],    | out
//          | is_last, char_count[3:0]                  |
//
// One transaction is accepted while idle, then its 32 bits are shifted one at a
// time through the shared dabble step, leading zeros are dropped (keeping at
// least one digit) and the count is latched; then one character is emitted per
// cycle while out_ready is high.
// in_ready is high only while idle; the next value is taken after the last
// character is accepted. A stalled output holds its character.
// rst is synchronous, active high, and returns the sequencer to idle.
module binary_to_decimal_ascii_unit #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0]   value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]    digit_char,
  output logic                           is_last,
  output logic [b2da_pkg::CNT_W-1:0]     char_count
);

  localparam int NDIG = (MAX_DIGITS < b2da_pkg::DEC_DIGITS_32) ?
                        MAX_DIGITS : b2da_pkg::DEC_DIGITS_32;
  localparam int DW = b2da_pkg::DIGIT_W;
  localparam int BCD_W = DW * NDIG;
  localparam int VW = b2da_pkg::VALUE_W;
  localparam int CW = b2da_pkg::CNT_W;
  localparam int BW = b2da_pkg::BIT_CNT_W;
  localparam logic [VW-1:0] LIMIT = b2da_pkg::sat_limit(MAX_DIGITS);
  localparam logic [BW-1:0] LAST_BIT = BW'(VW - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t            state;
  logic [VW-1:0]     shreg;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_next;
  logic [BW-1:0]     bit_cnt;
  logic [CW-1:0]     remaining;
  logic [CW-1:0]     total;
  logic [DW-1:0]     top_digit;

  b2da_dabble #(.NDIG(NDIG)) u_dabble (
    .bcd_in  (bcd),
    .bit_in  (shreg[VW-1]),
    .bcd_out (bcd_next)
  );

  assign top_digit = bcd[BCD_W-1 -: DW];

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_EMIT);
  assign digit_char = b2da_pkg::ASCII_ZERO | {2'b00, top_digit};
  assign is_last    = (remaining == CW'(1));
  assign char_count = is_last ? total : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_cnt   <= '0;
      remaining <= '0;
      total     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // Saturate values with more digits than the unit emits
            shreg   <= (value > LIMIT) ? LIMIT : value;
            bcd     <= '0;
            bit_cnt <= '0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd     <= bcd_next;
          shreg   <= {shreg[VW-2:0], 1'b0};
          bit_cnt <= bit_cnt + BW'(1);
          if (bit_cnt == LAST_BIT) begin
            remaining <= CW'(NDIG);
            state     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Drop leading zeros, keeping at least one digit
          if (top_digit == '0 && remaining > CW'(1)) begin
            bcd       <= bcd << DW;
            remaining <= remaining - CW'(1);
          end else begin
            total <= remaining;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (remaining == CW'(1)) begin
              state <= ST_IDLE;
            end else begin
              bcd       <= bcd << DW;
              remaining <= remaining - CW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("output valid while sequencer idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a value");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char[5:4] == 2'b11 && digit_char[3:0] <= 4'd9))
    else $error("character is not a decimal digit");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_last) |-> (char_count != '0 && char_count <= CW'(NDIG)))
    else $error("character count out of range on last character");

  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (remaining != '0 && remaining <= total))
    else $error("remaining character count inconsistent");

endmodule

// File: dv/binary_to_decimal_ascii_unit_test.sv
// Self-checking testbench for the binary to decimal ASCII conversion unit.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_test;

  localparam int DIGITS = b2da_pkg::MAX_DIGITS_DEF;
  localparam int N_PROBES = 20;
  localparam int N_PHASES = 5;
  localparam int PHASE_ITEMS = 48;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_CYCLES = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
    logic [b2da_pkg::CNT_W-1:0]  cnt;
  } digit_exp_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [b2da_pkg::VALUE_W-1:0] value;
  logic                         out_valid;
  logic                         out_ready;
  logic [b2da_pkg::CHAR_W-1:0]  digit_char;
  logic                         is_last;
  logic [b2da_pkg::CNT_W-1:0]   char_count;

  digit_exp_t digit_q[$];
  string      offer_text_q[$];
  int         errors = 0;
  int         cycle = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  int         holds_asked = 0;
  int         holds_served = 0;

  // Directed values; text is typed in only where it is obvious.
  logic [b2da_pkg::VALUE_W-1:0] probe_value [N_PROBES] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'd1000000000, 32'd999999999,
    32'h8000_0000, 32'hFFFF_FFFE, 32'd11, 32'd99, 32'd100, 32'd101, 32'd1000,
    32'd100000, 32'd1234567890, 32'hAAAA_AAAA, 32'h5555_5555, 32'd3999999999,
    32'h0000_FFFF
  };
  string probe_text [N_PROBES] = '{
    "0", "1", "9", "10", "4294967295", "1000000000", "999999999",
    "2147483648", "", "", "", "", "", "", "", "", "", "", "", ""
  };

  int snd_pcts [N_PHASES] = '{0, 59, 0, 25, 0};
  int rcv_pcts [N_PHASES] = '{0, 0, 59, 25, 0};

  binary_to_decimal_ascii_unit #(
    .MAX_DIGITS(DIGITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digit_char(digit_char),
    .is_last(is_last),
    .char_count(char_count)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] ten_to(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int j = 0; j < k; j++) p = p * 64'd10;
    return p;
  endfunction

  // Decimal text of a value, leading zeros dropped, saturated to DIGITS digits.
  function automatic string decimal_text(input logic [b2da_pkg::VALUE_W-1:0] v);
    logic [63:0] n;
    logic [63:0] p;
    logic [63:0] d;
    bit          started;
    string       s;
    n = {32'd0, v};
    p = ten_to((DIGITS - 1 < 19) ? DIGITS - 1 : 19);
    started = 1'b0;
    s = "";
    if (p <= 64'hFFFF_FFFF && n > p * 64'd10 - 64'd1) n = p * 64'd10 - 64'd1;
    while (p != 0) begin
      d = n / p;
      if (d != 0) started = 1'b1;
      if (started || p == 64'd1) begin
        s = $sformatf("%s%0d", s, d);
        n = n - d * p;
      end
      p = p / 64'd10;
    end
    return s;
  endfunction

  // Mix of full-range words, powers of ten with neighbors, and every digit length.
  function automatic logic [b2da_pkg::VALUE_W-1:0] pick_value();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] r;
    int          nd;
    case ($urandom_range(5))
      0: r = {32'd0, $urandom()};
      1: r = ten_to($urandom_range(9)) + $urandom_range(2) - 1;
      default: begin
        nd = $urandom_range(10, 1);
        lo = (nd == 1) ? 64'd0 : ten_to(nd - 1);
        hi = ten_to(nd) - 64'd1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        r = {32'd0, $urandom_range(hi[31:0], lo[31:0])};
      end
    endcase
    return r[b2da_pkg::VALUE_W-1:0];
  endfunction

  // Offer one value and hold it until the unit accepts it.
  task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v, input string text);
    offer_text_q.push_back(text);
    value <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (digit_q.size() != 0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Push expected characters on input transactions, check output transactions.
  always @(posedge clk) begin
    string      txt;
    digit_exp_t want;
    byte        b;
    if (!rst) begin
      if (in_valid && in_ready) begin
        txt = offer_text_q.pop_front();
        if (txt.len() == 0) txt = decimal_text(value);
        for (int i = 0; i < txt.len(); i++) begin
          b = txt[i];
          want.ch = b[b2da_pkg::CHAR_W-1:0];
          want.last = (i == txt.len() - 1);
          want.cnt = want.last ? b2da_pkg::CNT_W'(txt.len()) : '0;
          digit_q.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (digit_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("cycle %0d: unexpected character ch=%h last=%b cnt=%0d",
                     cycle, digit_char, is_last, char_count);
        end else begin
          want = digit_q.pop_front();
          if (digit_char !== want.ch || is_last !== want.last || char_count !== want.cnt) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("cycle %0d: expected ch=%h last=%b cnt=%0d, got ch=%h last=%b cnt=%0d",
                       cycle, want.ch, want.last, want.cnt, digit_char, is_last, char_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 25;
    rcv_stall_pct = 25;
    for (int i = 0; i < N_PROBES; i++) send_value(probe_value[i], probe_text[i]);
    drain_results();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      snd_idle_pct = snd_pcts[ph];
      rcv_stall_pct = rcv_pcts[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Block the output while values keep coming, so the input backs up.
        if (ph == 0 && n == 10) holds_asked++;
        send_value(pick_value(), "");
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && digit_q.size() == 0 && offer_text_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
